// File: hw/rtl/ilfq_pkg.sv
// Shared types and constants for the indexed list block: request and result
// transactions, request and status codes, and the command that drives the cell row.
// No dependencies.
`default_nettype none

package ilfq_pkg;

    // Default pool depth and pool size after reset
    localparam int DEPTH_DEF  = 64;
    localparam int POOL_RESET = 64;

    // Field widths
    localparam int DATA_W = 32;
    localparam int POS_W  = 7;
    localparam int FPOS_W = 6;
    localparam int SIZE_W = 7;

    // Request codes
    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_SEARCH = 2'd2,
        FUNC_CLEAR  = 2'd3
    } t_func;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NO_FREE   = 2'd1,
        STAT_BAD_POS   = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } t_status;

    // Request transaction
    typedef struct packed {
        t_func                     func;
        logic signed [DATA_W-1:0]  value_in;
        logic        [POS_W-1:0]   position;
    } t_in;

    // Result transaction
    typedef struct packed {
        t_status                   status;
        logic signed [DATA_W-1:0]  value_out;
        logic        [FPOS_W-1:0]  found_position;
        logic        [SIZE_W-1:0]  list_size;
    } t_out;

    // Per-cycle operation of the cell row
    typedef enum logic [2:0] {
        CELL_HOLD   = 3'd0,
        CELL_INSERT = 3'd1,
        CELL_REMOVE = 3'd2,
        CELL_SEARCH = 3'd3,
        CELL_SHIFT  = 3'd4
    } t_cell_op;

    typedef struct packed {
        t_cell_op                op;
        logic [POS_W-1:0]        pos;
        logic [DATA_W-1:0]       value;
    } t_cell_cmd;

endpackage

`default_nettype wire

// File: hw/rtl/ilfq_cell.sv
// One list element of the cell row: holds the element value and a scan lane word.
// Depends on ilfq_pkg.
`default_nettype none

module ilfq_cell #(
    parameter int DEPTH = ilfq_pkg::DEPTH_DEF,
    parameter int INDEX = 0
) (
    input  logic                        i_clk,
    input  ilfq_pkg::t_cell_cmd         i_cmd,
    input  logic [ilfq_pkg::DATA_W-1:0] i_left_value,
    input  logic [ilfq_pkg::DATA_W-1:0] i_right_value,
    input  logic [ilfq_pkg::DATA_W-1:0] i_right_lane,
    output logic [ilfq_pkg::DATA_W-1:0] o_value,
    output logic [ilfq_pkg::DATA_W-1:0] o_lane
);
    import ilfq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CW    = (IDX_W > POS_W) ? IDX_W : POS_W;

    logic [DATA_W-1:0] r_value;
    logic [DATA_W-1:0] r_lane;
    logic [CW-1:0]     w_pos;
    logic [CW-1:0]     w_idx;
    logic              w_at;
    logic              w_after;
    logic              w_match;

    // Locate this cell against the requested position
    assign w_pos   = CW'(i_cmd.pos);
    assign w_idx   = CW'(INDEX);
    assign w_at    = (w_pos == w_idx);
    assign w_after = (w_idx > w_pos);
    assign w_match = (r_value == i_cmd.value);

    // Open a gap, close a gap, mark a match or advance the lane
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            CELL_INSERT: begin
                if (w_after) begin
                    r_value <= i_left_value;
                end else if (w_at) begin
                    r_value <= i_cmd.value;
                end
            end
            CELL_REMOVE: begin
                if (w_at || w_after) begin
                    r_value <= i_right_value;
                end
                r_lane <= w_at ? r_value : '0;
            end
            CELL_SEARCH: begin
                r_lane <= {{(DATA_W-1){1'b0}}, w_match};
            end
            CELL_SHIFT: begin
                r_lane <= i_right_lane;
            end
            default: begin
            end
        endcase
    end

    assign o_value = r_value;
    assign o_lane  = r_lane;

endmodule

`default_nettype wire

// File: hw/rtl/ilfq_ctrl.sv
// Sequencer of the indexed list block: request decode, list size and pool size
// register, lane scan for search and remove, result register. Depends on ilfq_pkg.
`default_nettype none

module ilfq_ctrl #(
    parameter int DEPTH = ilfq_pkg::DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  ilfq_pkg::t_in               i_in,
    output logic                        o_done,
    output ilfq_pkg::t_out              o_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output ilfq_pkg::t_cell_cmd         o_cmd,
    input  logic [ilfq_pkg::DATA_W-1:0] i_lane0
);
    import ilfq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CW    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] POOL_MAX  = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] POOL_INIT =
        (POOL_RESET > DEPTH) ? CNT_W'(DEPTH) : CNT_W'(POOL_RESET);
    localparam logic REG_POOL_SIZE = 1'b0;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_pool;
    logic [CNT_W-1:0] r_size;
    logic [CNT_W-1:0] r_j;
    t_func            r_func;
    logic [POS_W-1:0] r_pos;
    logic             r_done;
    t_out             r_result;

    logic             w_accept;
    logic             w_cfg_wr;
    logic [CNT_W-1:0] w_pool_wr;
    logic [CW-1:0]    w_pos_c;
    logic [CW-1:0]    w_size_c;
    logic             w_full;
    logic             w_ins_ok;
    logic             w_rem_ok;

    assign w_accept = start && (r_state == ST_IDLE);
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == REG_POOL_SIZE);

    // Saturate a written pool size into 1 .. DEPTH
    always_comb begin
        if (pwdata == 32'd0) begin
            w_pool_wr = CNT_W'(1);
        end else if (pwdata > 32'(DEPTH)) begin
            w_pool_wr = POOL_MAX;
        end else begin
            w_pool_wr = CNT_W'(pwdata);
        end
    end

    // Request checks
    assign w_pos_c  = CW'(i_in.position);
    assign w_size_c = CW'(r_size);
    assign w_full   = (r_size == r_pool);
    assign w_ins_ok = !w_full && (w_pos_c <= w_size_c);
    assign w_rem_ok = (w_pos_c < w_size_c);

    // Drive the cell row
    always_comb begin
        o_cmd.op    = CELL_HOLD;
        o_cmd.pos   = i_in.position;
        o_cmd.value = i_in.value_in;
        if (w_accept) begin
            case (i_in.func)
                FUNC_INSERT: o_cmd.op = w_ins_ok ? CELL_INSERT : CELL_HOLD;
                FUNC_REMOVE: o_cmd.op = w_rem_ok ? CELL_REMOVE : CELL_HOLD;
                FUNC_SEARCH: o_cmd.op = CELL_SEARCH;
                default:     o_cmd.op = CELL_HOLD;
            endcase
        end else if (r_state == ST_SCAN) begin
            o_cmd.op = CELL_SHIFT;
        end
    end

    // Sequence requests, hold list size and pool size, register results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pool  <= POOL_INIT;
            r_size  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (w_cfg_wr) begin
                r_pool <= w_pool_wr;
                r_size <= '0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_func                   <= i_in.func;
                        r_pos                    <= i_in.position;
                        r_j                      <= '0;
                        r_result.status          <= STAT_OK;
                        r_result.value_out       <= '0;
                        r_result.found_position  <= '0;
                        r_result.list_size       <= SIZE_W'(r_size);
                        case (i_in.func)
                            FUNC_INSERT: begin
                                r_done <= 1'b1;
                                if (w_full) begin
                                    r_result.status <= STAT_NO_FREE;
                                end else if (!w_ins_ok) begin
                                    r_result.status <= STAT_BAD_POS;
                                end else begin
                                    r_size             <= r_size + 1'b1;
                                    r_result.list_size <= SIZE_W'(r_size + 1'b1);
                                end
                            end
                            FUNC_REMOVE: begin
                                if (!w_rem_ok) begin
                                    r_done          <= 1'b1;
                                    r_result.status <= STAT_BAD_POS;
                                end else begin
                                    r_size  <= r_size - 1'b1;
                                    r_state <= ST_SCAN;
                                end
                            end
                            FUNC_SEARCH: begin
                                r_state <= ST_SCAN;
                            end
                            default: begin
                                r_done             <= 1'b1;
                                r_size             <= '0;
                                r_result.list_size <= '0;
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    r_result.list_size <= SIZE_W'(r_size);
                    if (r_func == FUNC_REMOVE) begin
                        // Removed value reaches the head of the lane after pos shifts
                        if (CW'(r_j) == CW'(r_pos)) begin
                            r_done             <= 1'b1;
                            r_state            <= ST_IDLE;
                            r_result.status    <= STAT_OK;
                            r_result.value_out <= i_lane0;
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end else begin
                        // Test match flags in list order until a hit or the end
                        if (r_j == r_size) begin
                            r_done          <= 1'b1;
                            r_state         <= ST_IDLE;
                            r_result.status <= STAT_NOT_FOUND;
                        end else if (i_lane0[0]) begin
                            r_done                  <= 1'b1;
                            r_state                 <= ST_IDLE;
                            r_result.status         <= STAT_OK;
                            r_result.found_position <= FPOS_W'(r_j);
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;
    assign prdata   = (paddr[2] == REG_POOL_SIZE) ? 32'(r_pool) : 32'd0;
    assign pready   = 1'b1;

    // The list never outgrows the pool
    a_size_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_size <= r_pool)
        else $error("list size exceeds pool size");

    // The scan never runs past the end of the list
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_j <= r_size))
        else $error("scan index beyond list size");

    // Every accepted transaction either answers at once or starts a scan
    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_done || (r_state == ST_SCAN)))
        else $error("accepted transaction neither answered nor scanning");

    // A result always reports the current list size
    a_result_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_result.list_size == SIZE_W'(r_size)))
        else $error("result size disagrees with list size");

endmodule

`default_nettype wire

// File: hw/rtl/indexed_list_with_free_queue.sv
// Top level of the indexed list block: a row of list cells and its sequencer.
// Depends on ilfq_pkg, ilfq_cell and ilfq_ctrl.
//
// Use: present a request on i_in and raise start; it is taken at a clock edge
// with start high and busy low. Requests are insert at a position, remove at
// a position, search for a value and clear. Each request gives one result on
// o_result, shown for exactly one cycle with o_done high; the receiver cannot
// stall, so it must take every result in that cycle.
// The list is held in order along a row of DEPTH cells: insert and remove
// move all affected cells by one place together.
// Insert, clear and every refused request answer in the cycle after they are taken,
// busy stays low, and a new request may follow at once.
// Remove and search hold busy high while the removed value or the match flags walk
// one cell a cycle down the scan lane to cell 0; search stops at the first hit or
// at the end of the list.
// The APB port holds pool_size at address 0; a write saturates it into
// 1 .. DEPTH and empties the list. Write it only while the block is idle.
// Reset empties the list and sets pool_size to 64 (at most DEPTH). No clearing
// pass is needed: cells beyond the list size are never read.
`default_nettype none

module indexed_list_with_free_queue #(
    parameter int DEPTH = ilfq_pkg::DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  ilfq_pkg::t_in  i_in,
    output logic           o_done,
    output ilfq_pkg::t_out o_result,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import ilfq_pkg::*;

    t_cell_cmd         w_cmd;
    logic [DATA_W-1:0] w_value [DEPTH];
    logic [DATA_W-1:0] w_lane  [DEPTH];
    logic [DATA_W-1:0] w_left  [DEPTH];
    logic [DATA_W-1:0] w_right [DEPTH];
    logic [DATA_W-1:0] w_rlane [DEPTH];

    // Sequencer and configuration register
    ilfq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_in     (i_in),
        .o_done   (o_done),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_cmd    (w_cmd),
        .i_lane0  (w_lane[0])
    );

    // Row of list cells, each linked to both neighbours
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_left[g] = '0;
        end else begin : g_inner_l
            assign w_left[g] = w_value[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right[g] = '0;
            assign w_rlane[g] = '0;
        end else begin : g_inner_r
            assign w_right[g] = w_value[g+1];
            assign w_rlane[g] = w_lane[g+1];
        end

        ilfq_cell #(
            .DEPTH (DEPTH),
            .INDEX (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_cmd         (w_cmd),
            .i_left_value  (w_left[g]),
            .i_right_value (w_right[g]),
            .i_right_lane  (w_rlane[g]),
            .o_value       (w_value[g]),
            .o_lane        (w_lane[g])
        );
    end

endmodule

`default_nettype wire

// File: tb/indexed_list_with_free_queue_tb.sv
// Self-checking testbench for the indexed list block with its free node queue.
// Depends on ilfq_pkg and indexed_list_with_free_queue; predicts every result
// from its own copy of the node pool, free ring and pool_size.
`timescale 1ns / 1ps

module indexed_list_with_free_queue_tb;

    import ilfq_pkg::*;

    localparam int          DEPTH       = DEPTH_DEF;
    localparam logic [6:0]  NIL         = 7'(DEPTH);
    localparam logic [2:0]  REG_POOL    = 3'd0;
    localparam logic [2:0]  REG_UNUSED  = 3'd4;
    localparam int          CYCLE_LIMIT = 1000000;
    localparam int          PHASE_ITEMS = 150;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    logic        busy;
    t_in         i_in    = '0;
    logic        o_done;
    t_out        o_result;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    indexed_list_with_free_queue i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_in     (i_in),
        .o_done   (o_done),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predicted pool state: node store, list ends and free index ring
    int unsigned pool_sz;
    logic [31:0] node_val [DEPTH];
    logic [6:0]  node_lnk [DEPTH];
    logic [6:0]  head_idx;
    logic [6:0]  tail_idx;
    int unsigned list_len;
    logic [5:0]  ring [DEPTH];
    int unsigned ring_front;
    int unsigned ring_rear;
    int unsigned ring_free;

    t_out        pending_results [$];
    t_out        oldest;
    bit          gaps_on;
    int unsigned error_count;
    int unsigned requests_sent;
    int unsigned results_checked;
    int unsigned pool_settings;
    int unsigned cycle_count;

    function automatic logic [6:0] next_of(input logic [6:0] idx);
        return (idx < DEPTH) ? node_lnk[idx] : NIL;
    endfunction

    // Empty the list and refill the free ring in index order
    function automatic void empty_list();
        for (int k = 0; k < DEPTH; k++) begin
            node_val[k] = '0;
            node_lnk[k] = NIL;
            ring[k]     = 6'(k);
        end
        head_idx   = NIL;
        tail_idx   = NIL;
        list_len   = 0;
        ring_front = 0;
        ring_rear  = 0;
        ring_free  = pool_sz;
    endfunction

    // Hand a node index back to the rear of the free ring
    function automatic void recycle_node(input logic [6:0] idx);
        if (ring_free >= pool_sz || ring_rear >= DEPTH)
            return;
        ring[ring_rear] = idx[5:0];
        ring_rear       = (ring_rear + 1) % pool_sz;
        ring_free++;
    endfunction

    // Apply one request to the predicted pool and return its result
    function automatic t_out predict_list_op(input t_in req);
        t_out        r;
        logic [6:0]  pos;
        logic [6:0]  prev;
        logic [6:0]  idx;
        logic [6:0]  cur;
        logic [6:0]  nxt;
        bit          hit;
        int unsigned j;
        r        = '0;
        r.status = STAT_OK;
        pos      = req.position;
        case (req.func)
            FUNC_INSERT: begin
                if (ring_free == 0) begin
                    r.status = STAT_NO_FREE;
                end else if (pos > list_len) begin
                    r.status = STAT_BAD_POS;
                end else begin
                    idx        = {1'b0, ring[ring_front]};
                    ring_front = (ring_front + 1) % pool_sz;
                    ring_free--;
                    node_val[idx] = req.value_in;
                    if (pos == 0) begin
                        node_lnk[idx] = head_idx;
                        head_idx      = idx;
                        if (list_len == 0)
                            tail_idx = idx;
                    end else begin
                        prev = head_idx;
                        for (j = 0; j + 1 < pos; j++)
                            prev = next_of(prev);
                        node_lnk[idx] = next_of(prev);
                        if (prev < DEPTH)
                            node_lnk[prev] = idx;
                        if (prev == tail_idx)
                            tail_idx = idx;
                    end
                    list_len++;
                end
            end
            FUNC_REMOVE: begin
                if (pos >= list_len) begin
                    r.status = STAT_BAD_POS;
                end else begin
                    if (pos == 0) begin
                        idx      = head_idx;
                        head_idx = next_of(idx);
                        if (head_idx == NIL)
                            tail_idx = NIL;
                    end else begin
                        prev = head_idx;
                        for (j = 0; j + 1 < pos; j++)
                            prev = next_of(prev);
                        idx = next_of(prev);
                        if (prev < DEPTH)
                            node_lnk[prev] = next_of(idx);
                        if (idx == tail_idx)
                            tail_idx = prev;
                    end
                    r.value_out = (idx < DEPTH) ? node_val[idx] : '0;
                    recycle_node(idx);
                    list_len--;
                end
            end
            FUNC_SEARCH: begin
                r.status = STAT_NOT_FOUND;
                cur      = head_idx;
                hit      = 1'b0;
                for (j = 0; j < list_len && cur != NIL && !hit; j++) begin
                    if (cur < DEPTH && node_val[cur] == req.value_in) begin
                        hit              = 1'b1;
                        r.status         = STAT_OK;
                        r.found_position = 6'(j);
                    end else begin
                        cur = next_of(cur);
                    end
                end
            end
            default: begin
                // Clear: walk from the head and free the nodes in list order
                cur = head_idx;
                for (j = 0; j < DEPTH && cur != NIL; j++) begin
                    nxt = next_of(cur);
                    recycle_node(cur);
                    if (cur < DEPTH) begin
                        node_val[cur] = '0;
                        node_lnk[cur] = NIL;
                    end
                    cur = nxt;
                end
                head_idx = NIL;
                tail_idx = NIL;
                list_len = 0;
            end
        endcase
        r.list_size = 7'(list_len);
        return r;
    endfunction

    // Check each result against the oldest prediction
    always @(posedge i_clk) begin
        if (o_done) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: status %0d, list_size %0d",
                       o_result.status, o_result.list_size);
                error_count++;
            end else begin
                oldest = pending_results.pop_front();
                results_checked++;
                if (o_result.status !== oldest.status) begin
                    $error("status: expected %0d, got %0d", oldest.status, o_result.status);
                    error_count++;
                end
                if (o_result.value_out !== oldest.value_out) begin
                    $error("value_out: expected %0d, got %0d",
                           oldest.value_out, o_result.value_out);
                    error_count++;
                end
                if (o_result.found_position !== oldest.found_position) begin
                    $error("found_position: expected %0d, got %0d",
                           oldest.found_position, o_result.found_position);
                    error_count++;
                end
                if (o_result.list_size !== oldest.list_size) begin
                    $error("list_size: expected %0d, got %0d",
                           oldest.list_size, o_result.list_size);
                    error_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Present one request, hold it until taken, then record its prediction
    task automatic send_request(input t_func f, input logic [31:0] v, input logic [6:0] p);
        t_in         req;
        int unsigned gap;
        req.func     = f;
        req.value_in = v;
        req.position = p;
        gap = (gaps_on && $urandom_range(0, 9) > 2) ? $urandom_range(0, 17) : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in  <= req;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(predict_list_op(req));
        requests_sent++;
    endtask

    // Drop start and wait for every outstanding result
    task automatic settle_block();
        @(negedge i_clk);
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0 || busy);
    endtask

    task automatic write_pool_reg(input logic [2:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        start   <= 1'b0;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == REG_POOL) begin
            pool_sz = (data == 0) ? 1 : (data > DEPTH) ? DEPTH : data;
            pool_settings++;
            empty_list();
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic read_pool_reg();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= REG_POOL;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== pool_sz) begin
            $error("pool_size: expected %0d, got %0d", pool_sz, prdata);
            error_count++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Requests against an empty list at the reset pool size
    task automatic test_empty_list();
        read_pool_reg();
        send_request(FUNC_SEARCH, 32'd5, 7'd0);
        send_request(FUNC_REMOVE, 32'd0, 7'd0);
        send_request(FUNC_INSERT, 32'd9, 7'd1);
        send_request(FUNC_CLEAR, 32'hFFFF_FFFF, 7'd127);
    endtask

    // Extreme values at head, middle and tail; duplicates and bad positions
    task automatic test_edge_values();
        send_request(FUNC_INSERT, 32'h7FFF_FFFF, 7'd0);
        send_request(FUNC_INSERT, 32'h8000_0000, 7'd1);
        send_request(FUNC_INSERT, 32'hFFFF_FFFF, 7'd1);
        send_request(FUNC_INSERT, 32'h0000_0000, 7'd0);
        send_request(FUNC_INSERT, 32'hFFFF_FFFF, 7'd4);
        send_request(FUNC_SEARCH, 32'h8000_0000, 7'd0);
        send_request(FUNC_SEARCH, 32'hFFFF_FFFF, 7'd0);
        send_request(FUNC_SEARCH, 32'h1234_5678, 7'd0);
        send_request(FUNC_REMOVE, 32'd0, 7'd5);
        send_request(FUNC_REMOVE, 32'd0, 7'd4);
        send_request(FUNC_REMOVE, 32'd0, 7'd0);
        send_request(FUNC_INSERT, 32'd1, 7'd127);
        send_request(FUNC_REMOVE, 32'd0, 7'd64);
        send_request(FUNC_CLEAR, 32'd0, 7'd0);
        settle_block();
    endtask

    // Saturation of pool_size, full pool before bad position, unmapped address
    task automatic test_pool_size_limits();
        write_pool_reg(REG_POOL, 32'd0);
        read_pool_reg();
        send_request(FUNC_INSERT, 32'd3, 7'd0);
        send_request(FUNC_INSERT, 32'd4, 7'd5);
        settle_block();
        write_pool_reg(REG_UNUSED, 32'd5);
        read_pool_reg();
        send_request(FUNC_INSERT, 32'd4, 7'd1);
        send_request(FUNC_REMOVE, 32'd0, 7'd0);
        send_request(FUNC_INSERT, 32'd6, 7'd0);
        settle_block();
        write_pool_reg(REG_POOL, 32'd1000);
        read_pool_reg();
        write_pool_reg(REG_POOL, 32'hFFFF_FFFF);
        read_pool_reg();
        send_request(FUNC_SEARCH, 32'd6, 7'd0);
        settle_block();
    endtask

    // Mostly well-formed traffic with duplicate-rich values over several pool sizes
    task automatic test_random_traffic();
        int unsigned pool_plan [10] = '{1, 2, 3, 7, 16, 64, 31, 64, 0, 64};
        int unsigned ins_plan  [10] = '{45, 50, 55, 50, 50, 75, 45, 55, 50, 40};
        int unsigned clr_plan  [10] = '{3, 3, 3, 2, 2, 0, 2, 1, 2, 3};
        int unsigned roll;
        int unsigned k;
        t_func       f;
        logic [31:0] v;
        logic [6:0]  p;
        logic [6:0]  cur;
        for (int phase = 0; phase < 10; phase++) begin
            write_pool_reg(REG_POOL, (pool_plan[phase] != 0) ? pool_plan[phase]
                                                            : $urandom_range(1, DEPTH));
            read_pool_reg();
            gaps_on = (phase % 3 != 1);
            repeat (PHASE_ITEMS) begin
                roll = $urandom_range(0, 99);
                if (roll < clr_plan[phase])
                    f = FUNC_CLEAR;
                else if (roll < clr_plan[phase] + 20)
                    f = FUNC_SEARCH;
                else if (roll < clr_plan[phase] + 20 + ins_plan[phase])
                    f = FUNC_INSERT;
                else
                    f = FUNC_REMOVE;
                // Small values repeat often, so searches hit duplicates
                v = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 15) - 8) : $urandom;
                if (f == FUNC_SEARCH && list_len != 0 && $urandom_range(0, 9) < 6) begin
                    cur = head_idx;
                    k   = $urandom_range(0, list_len - 1);
                    repeat (k) cur = next_of(cur);
                    v = node_val[cur];
                end
                if ($urandom_range(0, 9) == 0)
                    p = 7'($urandom_range(0, 127));
                else if (f == FUNC_INSERT)
                    p = 7'($urandom_range(0, list_len));
                else if (f == FUNC_REMOVE && list_len != 0)
                    p = 7'($urandom_range(0, list_len - 1));
                else
                    p = 7'($urandom_range(0, 127));
                send_request(f, v, p);
            end
            settle_block();
        end
    endtask

    initial begin
        pool_sz = POOL_RESET;
        empty_list();
        gaps_on = 1'b1;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_list();
        test_edge_values();
        test_pool_size_limits();
        test_random_traffic();

        settle_block();
        repeat (DEPTH + 4) @(posedge i_clk);
        $display("Sent %0d requests across %0d pool_size writes; %0d results checked.",
                 requests_sent, pool_settings, results_checked);
        $display("Covered insert, remove, search and clear, full pool and bad positions.");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/ilfq_pkg.sv
hw/rtl/ilfq_cell.sv
hw/rtl/ilfq_ctrl.sv
hw/rtl/indexed_list_with_free_queue.sv
tb/indexed_list_with_free_queue_tb.sv
